// ----- sv/csc_pkg.sv -----
// Shared types, codes and calendar helpers for the clock setting controller.
// Used by csc_alarm_bank, csc_core and clock_setting_controller_top.
`default_nettype none

package csc_pkg;

  localparam int unsigned ALARM_COUNT_DEF = 5;
  localparam int unsigned HIT_W           = 5;

  localparam logic [15:0] BLINK_PERIOD_RST  = 16'd500;
  localparam logic [15:0] REPEAT_PERIOD_RST = 16'd100;

  localparam logic [1:0] MODE_DISPLAY  = 2'd0;
  localparam logic [1:0] MODE_SET_TIME = 2'd1;
  localparam logic [1:0] MODE_ALARM    = 2'd2;

  localparam logic [1:0] EV_NONE       = 2'd0;
  localparam logic [1:0] EV_WRITE_TIME = 2'd1;
  localparam logic [1:0] EV_STORED     = 2'd2;
  localparam logic [1:0] EV_REJECTED   = 2'd3;

  localparam logic [1:0] CFG_BLINK_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd1;
  localparam logic [1:0] CFG_ENABLE_MASK   = 2'd2;

  localparam logic [2:0] FLD_SECOND  = 3'd0;
  localparam logic [2:0] FLD_MINUTE  = 3'd1;
  localparam logic [2:0] FLD_HOUR    = 3'd2;
  localparam logic [2:0] FLD_WEEKDAY = 3'd3;
  localparam logic [2:0] FLD_DATE    = 3'd4;
  localparam logic [2:0] FLD_MONTH   = 3'd5;
  localparam logic [2:0] FLD_YEAR    = 3'd6;

  typedef enum logic [2:0] {
    MS_DISPLAY  = 3'b001,
    MS_SET_TIME = 3'b010,
    MS_ALARM    = 3'b100
  } mode_state_e;

  typedef enum logic [2:0] {
    IP_RELEASED = 3'b001,
    IP_PRESSED  = 3'b010,
    IP_REPEAT   = 3'b100
  } inc_phase_e;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] date;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tstamp_t;

  typedef struct packed {
    logic       command;
    logic [2:0] slot;
    logic [2:0] buttons;
    logic       inc_long;
    tstamp_t    tm;
  } item_t;

  typedef struct packed {
    logic [15:0] blink_period;
    logic [15:0] repeat_period;
    logic [4:0]  enable_mask;
    logic        clear_fired;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] field;
    logic       blink;
    tstamp_t    tm;
    logic [4:0] hits;
    logic [1:0] event_res;
  } result_t;

  typedef struct packed {
    logic       store_en;
    logic [2:0] slot;
    tstamp_t    store_time;
    logic       a0_en;
    tstamp_t    a0_time;
    logic       match_en;
    tstamp_t    now_time;
  } alarm_req_t;

  // Days in a month; an invalid month counts as 31 days.
  function automatic logic [4:0] days_of(logic [3:0] month, logic [6:0] year);
    logic [4:0] d;
    case (month) inside
      4'd2:                   d = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic time_ok(tstamp_t t);
    logic bad;
    bad = (t.hour > 5'd23) || (t.minute > 6'd59) || (t.second > 6'd59) ||
          (t.weekday == 3'd0) || (t.month == 4'd0) || (t.month > 4'd12) ||
          (t.date == 5'd0) || (t.date > days_of(t.month, t.year));
    return !bad;
  endfunction

  // Steps one field with calendar wrap; a month change clamps the date.
  function automatic tstamp_t bump(tstamp_t t, logic [2:0] fld);
    tstamp_t    r;
    logic [6:0] sum_ms;
    logic [5:0] sum_h;
    logic [5:0] sum_d;
    logic [7:0] sum_y;
    logic [3:0] m;
    logic [4:0] lim;
    r      = t;
    sum_ms = 7'd0;
    sum_h  = 6'd0;
    sum_d  = 6'd0;
    sum_y  = 8'd0;
    m      = 4'd0;
    lim    = 5'd0;
    unique case (fld)
      FLD_SECOND: begin
        sum_ms   = {1'b0, t.second} + 7'd1;
        r.second = (sum_ms >= 7'd60) ? 6'(sum_ms - 7'd60) : sum_ms[5:0];
      end
      FLD_MINUTE: begin
        sum_ms   = {1'b0, t.minute} + 7'd1;
        r.minute = (sum_ms >= 7'd60) ? 6'(sum_ms - 7'd60) : sum_ms[5:0];
      end
      FLD_HOUR: begin
        sum_h  = {1'b0, t.hour} + 6'd1;
        r.hour = (sum_h >= 6'd24) ? 5'(sum_h - 6'd24) : sum_h[4:0];
      end
      FLD_WEEKDAY: begin
        r.weekday = (t.weekday == 3'd7) ? 3'd1 : 3'(t.weekday + 3'd1);
      end
      FLD_DATE: begin
        lim    = days_of(t.month, t.year);
        sum_d  = {1'b0, t.date} + 6'd1;
        r.date = (sum_d > {1'b0, lim}) ? 5'd1 : sum_d[4:0];
      end
      FLD_MONTH: begin
        m       = (t.month >= 4'd12) ? 4'(t.month - 4'd12) : t.month;
        r.month = 4'(m + 4'd1);
        lim     = days_of(r.month, t.year);
        if (t.date > lim) begin
          r.date = lim;
        end
      end
      FLD_YEAR: begin
        sum_y  = {1'b0, t.year} + 8'd1;
        r.year = (sum_y >= 8'd100) ? 7'(sum_y - 8'd100) : sum_y[6:0];
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/csc_alarm_bank.sv -----
// Alarm time storage, triggered flags and the display-mode alarm compare.
// Depends on csc_pkg for the time stamp and request types.
`default_nettype none

module csc_alarm_bank
  import csc_pkg::*;
#(
  parameter int unsigned ALARM_COUNT = ALARM_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  alarm_req_t       req_i,
  input  logic [HIT_W-1:0] enable_mask_i,
  input  logic             clear_fired_i,
  output tstamp_t          a0_cur_o,
  output tstamp_t          a0_next_o,
  output logic [HIT_W-1:0] hits_o
);

  tstamp_t                alarm_q [ALARM_COUNT];
  logic [ALARM_COUNT-1:0] fired_q;
  logic [ALARM_COUNT-1:0] hit_own;

  for (genvar g = 0; g < ALARM_COUNT; g++) begin : g_entry
    if (g < HIT_W) begin : g_match
      assign hit_own[g] = enable_mask_i[g] && !fired_q[g] &&
                          (alarm_q[g].year   == req_i.now_time.year) &&
                          (alarm_q[g].month  == req_i.now_time.month) &&
                          (alarm_q[g].date   == req_i.now_time.date) &&
                          (alarm_q[g].hour   == req_i.now_time.hour) &&
                          (alarm_q[g].minute == req_i.now_time.minute);
    end else begin : g_nomatch
      assign hit_own[g] = 1'b0;
    end
  end

  for (genvar g = 0; g < HIT_W; g++) begin : g_hit
    if (g < ALARM_COUNT) begin : g_live
      assign hits_o[g] = hit_own[g];
    end else begin : g_dead
      assign hits_o[g] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALARM_COUNT; i++) begin
        alarm_q[i] <= '0;
      end
    end else if (step_i) begin
      for (int i = 0; i < ALARM_COUNT; i++) begin
        if (req_i.store_en && (32'(req_i.slot) == i)) begin
          alarm_q[i] <= req_i.store_time;
        end
      end
      if (req_i.a0_en) begin
        alarm_q[0] <= req_i.a0_time;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fired_q <= '0;
    end else if (clear_fired_i) begin
      fired_q <= '0;
    end else if (step_i && req_i.match_en) begin
      fired_q <= fired_q | hit_own;
    end
  end

  always_comb begin
    a0_next_o = alarm_q[0];
    if (req_i.store_en && (req_i.slot == 3'd0)) begin
      a0_next_o = req_i.store_time;
    end else if (req_i.a0_en) begin
      a0_next_o = req_i.a0_time;
    end
  end

  assign a0_cur_o = alarm_q[0];

endmodule

`default_nettype wire

// ----- sv/csc_core.sv -----
// Per-item logic: button machines, mode and field control, edit counters,
// current time and result formation. Depends on csc_pkg and csc_alarm_bank.
`default_nettype none

module csc_core
  import csc_pkg::*;
#(
  parameter int unsigned ALARM_COUNT = ALARM_COUNT_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam logic [4:0] SlotLimit = 5'(ALARM_COUNT);

  mode_state_e mode_q, mode_d;
  inc_phase_e  inc_q, inc_d;
  logic [2:0]  field_q, field_d, field_a;
  logic [3:0]  field_sum;
  logic        blink_q, blink_d;
  logic        mode_btn_q, mode_btn_d;
  logic        set_btn_q, set_btn_d;
  tstamp_t     now_q, now_d;
  logic [15:0] blink_cnt_q, blink_cnt_d;
  logic [15:0] rep_cnt_q, rep_cnt_d, rep_base;
  logic        bump_en, rep_reload, store_ok;
  logic        pm, pi, ps;
  logic [1:0]  ev;
  alarm_req_t  req;
  tstamp_t     a0_cur, a0_next;
  logic [HIT_W-1:0] hits;

  assign pm = item_i.buttons[0];
  assign pi = item_i.buttons[1];
  assign ps = item_i.buttons[2];
  assign store_ok = ({2'b00, item_i.slot} < SlotLimit) && time_ok(item_i.tm);

  always_comb begin
    mode_d      = mode_q;
    inc_d       = inc_q;
    field_a     = field_q;
    field_d     = field_q;
    field_sum   = 4'd0;
    blink_d     = blink_q;
    mode_btn_d  = mode_btn_q;
    set_btn_d   = set_btn_q;
    now_d       = now_q;
    blink_cnt_d = blink_cnt_q;
    rep_cnt_d   = rep_cnt_q;
    rep_base    = rep_cnt_q;
    bump_en     = 1'b0;
    rep_reload  = 1'b0;
    ev          = EV_NONE;
    req         = '0;
    req.slot       = item_i.slot;
    req.store_time = item_i.tm;
    req.now_time   = item_i.tm;
    req.a0_time    = bump(a0_cur, field_q);

    if (item_i.command) begin
      req.store_en = store_ok;
      ev           = store_ok ? EV_STORED : EV_REJECTED;
    end else begin
      if (!mode_btn_q) begin
        if (pm) begin
          unique case (mode_q)
            MS_DISPLAY: begin
              mode_d  = MS_SET_TIME;
              field_a = FLD_SECOND;
            end
            MS_SET_TIME: mode_d = MS_ALARM;
            default:     mode_d = MS_DISPLAY;
          endcase
          mode_btn_d = 1'b1;
        end
      end else if (!pm) begin
        mode_btn_d = 1'b0;
      end
      field_d     = field_a;
      req.a0_time = bump(a0_cur, field_a);

      unique case (inc_q)
        IP_PRESSED: begin
          if (!pi) begin
            inc_d = IP_RELEASED;
          end else if (item_i.inc_long) begin
            inc_d      = IP_REPEAT;
            rep_reload = 1'b1;
          end
        end
        IP_REPEAT: begin
          if (!pi) begin
            inc_d = IP_RELEASED;
          end else if (rep_cnt_q == 16'd0) begin
            bump_en    = 1'b1;
            rep_reload = 1'b1;
          end
        end
        default: begin
          inc_d = IP_RELEASED;
          if (pi) begin
            bump_en = 1'b1;
            inc_d   = IP_PRESSED;
          end
        end
      endcase

      if (bump_en && (mode_d == MS_SET_TIME)) begin
        now_d = bump(now_q, field_a);
      end
      req.a0_en = bump_en && (mode_d == MS_ALARM);

      if (!set_btn_q) begin
        if (ps) begin
          if (mode_d == MS_SET_TIME) begin
            ev = EV_WRITE_TIME;
          end
          field_sum = {1'b0, field_a} + 4'd1;
          field_d   = (field_sum >= 4'd7) ? 3'(field_sum - 4'd7) : field_sum[2:0];
          set_btn_d = 1'b1;
        end
      end else if (!ps) begin
        set_btn_d = 1'b0;
      end

      if (mode_d == MS_DISPLAY) begin
        now_d        = item_i.tm;
        req.match_en = 1'b1;
      end else if (blink_cnt_q == 16'd0) begin
        blink_d     = !blink_q;
        blink_cnt_d = cfg_i.blink_period;
      end

      if (blink_cnt_d != 16'd0) begin
        blink_cnt_d = blink_cnt_d - 16'd1;
      end
      rep_base  = rep_reload ? cfg_i.repeat_period : rep_cnt_q;
      rep_cnt_d = (rep_base != 16'd0) ? rep_base - 16'd1 : rep_base;
    end
  end

  csc_alarm_bank #(
    .ALARM_COUNT(ALARM_COUNT)
  ) u_alarm_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step_i),
    .req_i        (req),
    .enable_mask_i(cfg_i.enable_mask),
    .clear_fired_i(cfg_i.clear_fired),
    .a0_cur_o     (a0_cur),
    .a0_next_o    (a0_next),
    .hits_o       (hits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MS_DISPLAY;
      inc_q       <= IP_RELEASED;
      field_q     <= FLD_SECOND;
      blink_q     <= 1'b0;
      mode_btn_q  <= 1'b0;
      set_btn_q   <= 1'b0;
      now_q       <= '0;
      blink_cnt_q <= '0;
      rep_cnt_q   <= '0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      inc_q       <= inc_d;
      field_q     <= field_d;
      blink_q     <= blink_d;
      mode_btn_q  <= mode_btn_d;
      set_btn_q   <= set_btn_d;
      now_q       <= now_d;
      blink_cnt_q <= blink_cnt_d;
      rep_cnt_q   <= rep_cnt_d;
    end
  end

  always_comb begin
    unique case (mode_d)
      MS_SET_TIME: result_o.mode = MODE_SET_TIME;
      MS_ALARM:    result_o.mode = MODE_ALARM;
      default:     result_o.mode = MODE_DISPLAY;
    endcase
    result_o.field     = field_d;
    result_o.blink     = blink_d;
    result_o.tm        = (mode_d == MS_ALARM) ? a0_next : now_d;
    result_o.hits      = req.match_en ? hits : '0;
    result_o.event_res = ev;
  end

endmodule

`default_nettype wire

// ----- sv/clock_setting_controller_top.sv -----
// Top level of the clock setting controller: input register, configuration
// registers and result register around csc_core. Depends on csc_pkg and csc_core.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o) takes one item per poll tick: the
//   button levels, the long-press flag and the clock time, or a store alarm
//   command with its slot and alarm time.
// - Output channel (out_valid_o/out_ready_i) returns exactly one result item
//   per input item: mode, edited field, blink state, the time on view, newly
//   triggered alarms and an event code.
// - Configuration channel (cfg_valid_i/cfg_ready_o) writes blink period,
//   repeat period and alarm enable mask; it is always ready. Writing the
//   enable mask clears every triggered flag.
// - The result item passes from the input register into the result register,
//   which the per-item logic writes once the result register is free.
// - Throughput is one item per cycle while the receiver does not stall; the single result register sets it.
// - When the receiver stalls, the result register holds and the input
//   register still takes one more item; after that in_ready_o drops.
// - Reset clears the controller to display mode, zero times and the default
//   periods; there is no start-up sweep.
`default_nettype none

module clock_setting_controller_top
  import csc_pkg::*;
#(
  parameter int unsigned ALARM_COUNT = ALARM_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [2:0]  alarm_slot_i,
  input  logic [2:0]  buttons_i,
  input  logic        increase_long_i,
  input  logic [5:0]  in_second_i,
  input  logic [5:0]  in_minute_i,
  input  logic [4:0]  in_hour_i,
  input  logic [2:0]  in_weekday_i,
  input  logic [4:0]  in_date_i,
  input  logic [3:0]  in_month_i,
  input  logic [6:0]  in_year_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  mode_o,
  output logic [2:0]  edit_field_o,
  output logic        blink_on_o,
  output logic [5:0]  show_second_o,
  output logic [5:0]  show_minute_o,
  output logic [4:0]  show_hour_o,
  output logic [2:0]  show_weekday_o,
  output logic [4:0]  show_date_o,
  output logic [3:0]  show_month_o,
  output logic [6:0]  show_year_o,
  output logic [4:0]  alarm_hits_o,
  output logic [1:0]  event_res_o
);

  logic        s1_valid_q;
  item_t       item_q;
  logic        out_valid_q;
  result_t     res_q, res_d;
  logic [15:0] blink_period_q, repeat_period_q;
  logic [4:0]  enable_mask_q;
  logic        out_free, step, in_fire, cfg_fire;
  cfg_t        cfg;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.command    <= command_i;
      item_q.slot       <= alarm_slot_i;
      item_q.buttons    <= buttons_i;
      item_q.inc_long   <= increase_long_i;
      item_q.tm.second  <= in_second_i;
      item_q.tm.minute  <= in_minute_i;
      item_q.tm.hour    <= in_hour_i;
      item_q.tm.weekday <= in_weekday_i;
      item_q.tm.date    <= in_date_i;
      item_q.tm.month   <= in_month_i;
      item_q.tm.year    <= in_year_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q  <= BLINK_PERIOD_RST;
      repeat_period_q <= REPEAT_PERIOD_RST;
      enable_mask_q   <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_BLINK_PERIOD:  blink_period_q  <= cfg_data_i;
        CFG_REPEAT_PERIOD: repeat_period_q <= cfg_data_i;
        CFG_ENABLE_MASK:   enable_mask_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign cfg.blink_period  = blink_period_q;
  assign cfg.repeat_period = repeat_period_q;
  assign cfg.enable_mask   = enable_mask_q;
  assign cfg.clear_fired   = cfg_fire && (cfg_index_i == CFG_ENABLE_MASK);

  csc_core #(
    .ALARM_COUNT(ALARM_COUNT)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mode_o         = res_q.mode;
  assign edit_field_o   = res_q.field;
  assign blink_on_o     = res_q.blink;
  assign show_second_o  = res_q.tm.second;
  assign show_minute_o  = res_q.tm.minute;
  assign show_hour_o    = res_q.tm.hour;
  assign show_weekday_o = res_q.tm.weekday;
  assign show_date_o    = res_q.tm.date;
  assign show_month_o   = res_q.tm.month;
  assign show_year_o    = res_q.tm.year;
  assign alarm_hits_o   = res_q.hits;
  assign event_res_o    = res_q.event_res;

`ifndef SYNTHESIS
  a_hits_only_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (alarm_hits_o != '0) |->
      (mode_o == MODE_DISPLAY) && (event_res_o == EV_NONE))
    else $error("Alarm hits reported outside a display-mode tick.");

  a_write_in_set_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_WRITE_TIME) |-> (mode_o == MODE_SET_TIME))
    else $error("Time write event reported outside change time mode.");

  a_field_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (edit_field_o <= FLD_YEAR))
    else $error("Edited field index out of range.");

  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (mode_o == MODE_DISPLAY) || (mode_o == MODE_SET_TIME) || (mode_o == MODE_ALARM))
    else $error("Mode output carries an unused code.");

  a_stage_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_o && !out_ready_i |=> s1_valid_q && out_valid_o)
    else $error("Item lost while the result register was stalled.");
`endif

endmodule

`default_nettype wire
